// ===== rtl/iec104fs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iec104fs_pkg: shared types and constants for the APCI frame splitter
// Register indexes, reset values, control-field masks and the structs that
// move between the splitter's modules.
// ----------------------------------------------------------------------------
package iec104fs_pkg;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_START_MARKER = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_SEG_LEN  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_INVALID  = 2'd2;

  localparam logic [7:0]  START_MARKER_RST = 8'd104;
  localparam logic [7:0]  MIN_SEG_LEN_RST  = 8'd6;
  localparam logic [15:0] MAX_INVALID_RST  = 16'd2560;

  localparam logic [7:0] CTRL_KIND_MASK = 8'h03;
  localparam logic [7:0] CTRL_FUNC_MASK = 8'hFC;
  localparam logic [7:0] CTRL_SEQ_BIT   = 8'h01;

  localparam logic [1:0] KIND_U = 2'b11;
  localparam logic [1:0] KIND_S = 2'b01;

  typedef enum logic [1:0] {
    VERDICT_SEARCH = 2'd0,
    VERDICT_FLUSH  = 2'd1,
    VERDICT_ABORT  = 2'd2
  } verdict_t;

  typedef enum logic [2:0] {
    PH_START = 3'b001,
    PH_LEN   = 3'b010,
    PH_FLUSH = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0]  start_marker;
    logic [7:0]  min_segment_length;
    logic [15:0] max_invalid_octets;
  } cfg_t;

  typedef struct packed {
    logic [5:0][7:0] bytes;
    logic [15:0]     length;
  } seg_t;

  typedef struct packed {
    verdict_t   verdict;
    logic [8:0] flush_point;
  } res_t;

endpackage

// ===== rtl/iec104_frame_splitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iec104_frame_splitter: APCI framing over TCP segment headers
// Takes one segment header per beat and returns one verdict per segment.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with the first six segment bytes and the
// segment length. Output channel: out_valid / out_stall with verdict (search,
// flush, abort) and flush_point. A beat moves when valid is high and stall is
// low. Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high. Write only while no segment is in flight.
// A segment accepted into the input register has its result loaded into the
// output register once that register is free. Throughput: one segment per
// cycle while out_stall is low, set by the single input register and single
// result register around the framing logic.
// Reset clears both pipeline registers, returns to the start phase with a
// valid frame and a zero invalid count, and loads the default registers.
// When out_stall holds a result, the input register keeps one more segment;
// in_stall rises only while both registers are full and the output stalls.
// ----------------------------------------------------------------------------
module iec104_frame_splitter (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           seg_byte_0,
  input  logic [7:0]                           seg_byte_1,
  input  logic [7:0]                           seg_byte_2,
  input  logic [7:0]                           seg_byte_3,
  input  logic [7:0]                           seg_byte_4,
  input  logic [7:0]                           seg_byte_5,
  input  logic [15:0]                          segment_length,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           verdict,
  output logic [8:0]                           flush_point,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [iec104fs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [iec104fs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  iec104fs_pkg::cfg_t cfg;
  iec104fs_pkg::seg_t s1_seg;
  iec104fs_pkg::res_t step_res;
  iec104fs_pkg::res_t out_res;
  logic               s1_valid;
  logic               out_free;
  logic               advance;
  logic               in_accept;

  iec104fs_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign out_free  = !out_valid || !out_stall;
  assign advance   = s1_valid && out_free;
  assign in_stall  = s1_valid && !out_free;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_seg.bytes[0] <= seg_byte_0;
      s1_seg.bytes[1] <= seg_byte_1;
      s1_seg.bytes[2] <= seg_byte_2;
      s1_seg.bytes[3] <= seg_byte_3;
      s1_seg.bytes[4] <= seg_byte_4;
      s1_seg.bytes[5] <= seg_byte_5;
      s1_seg.length   <= segment_length;
    end
  end

  iec104fs_frame_step u_frame_step (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .seg     (s1_seg),
    .cfg     (cfg),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // load the result register only when the segment leaves stage one
  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign verdict     = out_res.verdict;
  assign flush_point = out_res.flush_point;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled with a free stage");

  a_held_item_moves: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_valid |=> out_valid)
    else $error("staged segment did not reach the result register");

  a_point_only_on_flush: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.verdict != iec104fs_pkg::VERDICT_FLUSH |-> out_res.flush_point == 9'd0)
    else $error("flush point set on a non-flush verdict");

endmodule

// ===== rtl/iec104fs_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iec104fs_cfg_regs: configuration register file
// Holds start marker, minimum segment length and the invalid byte limit.
// Writes to an index past the last register are dropped.
// ----------------------------------------------------------------------------
module iec104fs_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [iec104fs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [iec104fs_pkg::CFG_DATA_W-1:0]  cfg_data,
  output iec104fs_pkg::cfg_t                   cfg
);

  iec104fs_pkg::cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg       = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.start_marker       <= iec104fs_pkg::START_MARKER_RST;
      regs.min_segment_length <= iec104fs_pkg::MIN_SEG_LEN_RST;
      regs.max_invalid_octets <= iec104fs_pkg::MAX_INVALID_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        iec104fs_pkg::CFG_START_MARKER: regs.start_marker       <= cfg_data[7:0];
        iec104fs_pkg::CFG_MIN_SEG_LEN:  regs.min_segment_length <= cfg_data[7:0];
        iec104fs_pkg::CFG_MAX_INVALID:  regs.max_invalid_octets <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/iec104fs_ctrl_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iec104fs_ctrl_check: APCI control field check
// Classifies the frame as U, S or I from control field one and checks the
// fields that each format requires.
// ----------------------------------------------------------------------------
module iec104fs_ctrl_check (
  input  logic [7:0] ctrl_1,
  input  logic [7:0] ctrl_2,
  input  logic [7:0] ctrl_3,
  input  logic [7:0] ctrl_4,
  output logic       ok
);

  logic [1:0] kind;
  logic [7:0] func;
  logic       func_single;
  logic       seq_clear;

  assign kind        = ctrl_1[1:0] & iec104fs_pkg::CTRL_KIND_MASK[1:0];
  assign func        = ctrl_1 & iec104fs_pkg::CTRL_FUNC_MASK;
  assign func_single = (func != 8'd0) && ((func & (func - 8'd1)) == 8'd0);
  assign seq_clear   = (ctrl_3 & iec104fs_pkg::CTRL_SEQ_BIT) == 8'd0;

  always_comb begin
    priority if (kind == iec104fs_pkg::KIND_U) begin
      ok = ((ctrl_2 | ctrl_3 | ctrl_4) == 8'd0) && func_single;
    end else if (kind == iec104fs_pkg::KIND_S) begin
      ok = (ctrl_1 == iec104fs_pkg::CTRL_SEQ_BIT) && (ctrl_2 == 8'd0) && seq_clear;
    end else begin
      ok = seq_clear;
    end
  end

endmodule

// ===== rtl/iec104fs_frame_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iec104fs_frame_step: framing state and per-segment decision
// Walks up to three leading positions of a segment through the start, length
// and flush phases, tracks frame validity and the saturating invalid count,
// and forms the verdict. State commits only when the result is taken.
// ----------------------------------------------------------------------------
module iec104fs_frame_step (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  iec104fs_pkg::seg_t seg,
  input  iec104fs_pkg::cfg_t cfg,
  output iec104fs_pkg::res_t res
);

  iec104fs_pkg::phase_t phase, phase_next;
  logic [7:0]           frame_length, frame_length_next;
  logic                 frame_valid, frame_valid_next;
  logic [31:0]          invalid_byte_count, invalid_byte_count_next;

  logic        ctrl_ok;
  logic        has1, has2, has3;
  logic        valid_w;
  logic        flush;
  logic [8:0]  fp;
  logic [32:0] count_sum;
  logic [7:0]  b0, b1;

  iec104fs_ctrl_check u_ctrl_check (
    .ctrl_1 (seg.bytes[2]),
    .ctrl_2 (seg.bytes[3]),
    .ctrl_3 (seg.bytes[4]),
    .ctrl_4 (seg.bytes[5]),
    .ok     (ctrl_ok)
  );

  assign b0   = seg.bytes[0];
  assign b1   = seg.bytes[1];
  assign has1 = seg.length != 16'd0;
  assign has2 = seg.length >= 16'd2;
  assign has3 = seg.length >= 16'd3;
  assign count_sum = {1'b0, invalid_byte_count} + {17'd0, seg.length};

  always_comb begin
    phase_next              = phase;
    frame_length_next       = frame_length;
    invalid_byte_count_next = invalid_byte_count;
    flush                   = 1'b0;
    fp                      = 9'd0;
    valid_w = frame_valid && (seg.length >= {8'd0, cfg.min_segment_length}) && ctrl_ok;

    unique case (phase)
      iec104fs_pkg::PH_START: begin
        if (has1) begin
          phase_next = iec104fs_pkg::PH_LEN;
          if (b0 != cfg.start_marker) valid_w = 1'b0;
        end
        if (has2) begin
          frame_length_next = b1;
          phase_next        = iec104fs_pkg::PH_FLUSH;
          if ({8'd0, b1} > seg.length) valid_w = 1'b0;
        end
        if (has3) begin
          flush = 1'b1;
          fp    = {1'b0, b1} + 9'd2;
        end
      end
      iec104fs_pkg::PH_LEN: begin
        if (has1) begin
          frame_length_next = b0;
          phase_next        = iec104fs_pkg::PH_FLUSH;
          if ({8'd0, b0} > seg.length) valid_w = 1'b0;
        end
        if (has2) begin
          flush = 1'b1;
          fp    = {1'b0, b0} + 9'd1;
        end
      end
      iec104fs_pkg::PH_FLUSH: begin
        if (has1) begin
          flush = 1'b1;
          fp    = {1'b0, frame_length};
        end
      end
      default: ;
    endcase

    res.verdict      = iec104fs_pkg::VERDICT_SEARCH;
    res.flush_point  = 9'd0;
    frame_valid_next = valid_w;

    if (flush) begin
      phase_next        = iec104fs_pkg::PH_START;
      frame_length_next = 8'd0;
      frame_valid_next  = 1'b1;
      if (!valid_w) begin
        // saturate at all ones
        invalid_byte_count_next = count_sum[32] ? '1 : count_sum[31:0];
        if (invalid_byte_count_next > {16'd0, cfg.max_invalid_octets}) begin
          res.verdict = iec104fs_pkg::VERDICT_ABORT;
        end else begin
          res.verdict     = iec104fs_pkg::VERDICT_FLUSH;
          res.flush_point = fp;
        end
      end else begin
        invalid_byte_count_next = 32'd0;
        res.verdict             = iec104fs_pkg::VERDICT_FLUSH;
        res.flush_point         = fp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= iec104fs_pkg::PH_START;
      frame_length       <= 8'd0;
      frame_valid        <= 1'b1;
      invalid_byte_count <= 32'd0;
    end else if (advance) begin
      phase              <= phase_next;
      frame_length       <= frame_length_next;
      frame_valid        <= frame_valid_next;
      invalid_byte_count <= invalid_byte_count_next;
    end
  end

  a_start_len_zero: assert property (@(posedge clk) disable iff (rst)
    phase == iec104fs_pkg::PH_START |-> frame_length == 8'd0)
    else $error("frame length not cleared in start phase");

  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    advance && res.verdict != iec104fs_pkg::VERDICT_SEARCH
      |=> phase == iec104fs_pkg::PH_START && frame_valid)
    else $error("frame end did not return to start phase");

  a_abort_over_limit: assert property (@(posedge clk) disable iff (rst)
    advance && res.verdict == iec104fs_pkg::VERDICT_ABORT
      |=> invalid_byte_count > {16'd0, $past(cfg.max_invalid_octets)})
    else $error("abort with invalid count within limit");

  a_search_keeps_count: assert property (@(posedge clk) disable iff (rst)
    advance && res.verdict == iec104fs_pkg::VERDICT_SEARCH
      |=> $stable(invalid_byte_count))
    else $error("invalid count moved without a frame end");

endmodule
